>>> rtl/tms_pkg.sv
// Shared types and constants of the Turing machine step unit.
// No dependencies; every other file refers to it by scoped names.
package tms_pkg;

    localparam int TAPE_CELLS   = 256;
    localparam int SYMBOL_COUNT = 256;
    localparam int STATE_COUNT  = 128;

    localparam int TAPE_AW = $clog2(TAPE_CELLS);
    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int ST_W    = $clog2(STATE_COUNT);
    localparam int RULE_AW = ST_W + SYM_W;

    // fixed field widths of the channels
    localparam int MODE_FW  = 3;
    localparam int STATE_FW = 7;
    localparam int SYM_FW   = 8;
    localparam int MOVE_FW  = 2;
    localparam int IDX_FW   = 8;

    localparam logic [SYM_FW-1:0]   BLANK_SYMBOL = 8'd48;
    localparam logic [TAPE_AW-1:0]  HEAD_RESET   = TAPE_AW'(128 % TAPE_CELLS);
    localparam logic [STATE_FW-1:0] HALT_RESET   = 7'd26;

    localparam logic [MOVE_FW-1:0] MOVE_RIGHT = 2'b01;
    localparam logic [MOVE_FW-1:0] MOVE_LEFT  = 2'b11;

    typedef enum logic [MODE_FW-1:0] {
        MODE_RULE = 3'd0,
        MODE_CELL = 3'd1,
        MODE_SET  = 3'd2,
        MODE_STEP = 3'd3,
        MODE_READ = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RULE
    } t_fsm;

    typedef struct packed {
        logic [SYM_FW-1:0]  sym;
        logic [MOVE_FW-1:0] move;
        logic [ST_W-1:0]    next;
    } t_rule;

    typedef struct packed {
        logic [MODE_FW-1:0]  mode;
        logic [STATE_FW-1:0] next_state;
        logic [TAPE_AW-1:0]  cidx;
    } t_cmd;

    typedef struct packed {
        logic               rd_en;
        logic [TAPE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [TAPE_AW-1:0] wr_addr;
        logic [SYM_FW-1:0]  wr_data;
    } t_tape_req;

endpackage

>>> rtl/tms_if.sv
// Channel interfaces of the Turing machine step unit: commands, results, config.
// Depends on tms_pkg for field widths.
interface tms_in_if;
    logic                          valid;
    logic                          ready;
    logic [tms_pkg::MODE_FW-1:0]   mode;
    logic [tms_pkg::STATE_FW-1:0]  table_state;
    logic [tms_pkg::SYM_FW-1:0]    read_symbol;
    logic [tms_pkg::SYM_FW-1:0]    write_symbol;
    logic signed [tms_pkg::MOVE_FW-1:0] move_dir;
    logic [tms_pkg::STATE_FW-1:0]  next_state;
    logic [tms_pkg::IDX_FW-1:0]    cell_index;

    modport source (output valid, mode, table_state, read_symbol, write_symbol,
                    move_dir, next_state, cell_index, input ready);
    modport sink   (input valid, mode, table_state, read_symbol, write_symbol,
                    move_dir, next_state, cell_index, output ready);
endinterface

interface tms_out_if;
    logic                          valid;
    logic                          ready;
    logic [tms_pkg::STATE_FW-1:0]  current_state;
    logic [tms_pkg::IDX_FW-1:0]    head_position;
    logic [tms_pkg::SYM_FW-1:0]    symbol_seen;
    logic                          halted;
    logic                          step_done;

    modport source (output valid, current_state, head_position, symbol_seen,
                    halted, step_done, input ready);
    modport sink   (input valid, current_state, head_position, symbol_seen,
                    halted, step_done, output ready);
endinterface

interface tms_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tms_pkg::STATE_FW-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/tms_tape.sv
// Tape memory: one write and one registered read per cycle, with a valid bit
// per cell so unwritten cells read as the blank symbol. Depends on tms_pkg.
module tms_tape (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tms_pkg::t_tape_req         i_req,
    output logic [tms_pkg::SYM_FW-1:0] o_rd_data
);

    logic [tms_pkg::SYM_FW-1:0] r_mem [tms_pkg::TAPE_CELLS];
    logic [tms_pkg::TAPE_CELLS-1:0] r_vld;
    logic [tms_pkg::SYM_FW-1:0] r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : tms_pkg::BLANK_SYMBOL;

endmodule

>>> rtl/turing_machine_step_unit.sv
// Top level of the Turing machine step unit: command decode, rule table and
// head/state registers. Depends on tms_pkg, tms_if and tms_tape.
//
// One command is taken at a time. A step passes from acceptance to its result
// register through the tape read under the head, the rule table read
// addressed by the state and that symbol, then the tape write-back with the
// head and state update. Every other command, and a step in the halt state,
// finishes after the registered tape read alone. The next command is
// accepted in the cycle after a result is registered, also while that result
// still waits to be taken; a command whose result finds the register full
// holds until it drains. After reset the tape reads as blank (48) at once,
// with no clearing pass. Rule entries must be written before a step uses them.
module turing_machine_step_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tms_in_if.sink    i_in,
    tms_out_if.source o_out,
    tms_cfg_if.sink   i_cfg
);

    tms_pkg::t_fsm  r_fsm, n_fsm;
    tms_pkg::t_cmd  r_cmd;
    tms_pkg::t_rule r_rule_rd;
    tms_pkg::t_rule r_rule [2**tms_pkg::RULE_AW];
    tms_pkg::t_tape_req tape_req;

    logic [tms_pkg::TAPE_AW-1:0]  r_head, n_head, moved_head;
    logic [tms_pkg::ST_W-1:0]     r_state, n_state;
    logic [tms_pkg::STATE_FW-1:0] r_halt;
    logic [tms_pkg::SYM_FW-1:0]   tape_sym, seen;

    logic                         r_out_valid;
    logic [tms_pkg::STATE_FW-1:0] r_out_state;
    logic [tms_pkg::IDX_FW-1:0]   r_out_head;
    logic [tms_pkg::SYM_FW-1:0]   r_out_seen;
    logic                         r_out_halted;
    logic                         r_out_done;

    logic in_acc, out_free, step_go, finish;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign step_go  = (r_cmd.mode == tms_pkg::MODE_STEP) &&
                      (tms_pkg::STATE_FW'(r_state) != r_halt);

    // configuration
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt <= tms_pkg::HALT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_halt <= i_cfg.data;
        end
    end

    // sequencer
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            tms_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_fsm = tms_pkg::S_READ;
                end
            end
            tms_pkg::S_READ: begin
                if (step_go) begin
                    n_fsm = tms_pkg::S_RULE;
                end else if (out_free) begin
                    n_fsm = tms_pkg::S_IDLE;
                end
            end
            tms_pkg::S_RULE: begin
                if (out_free) begin
                    n_fsm = tms_pkg::S_IDLE;
                end
            end
            default: n_fsm = tms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        finish = 1'b0;
        unique case (r_fsm)
            tms_pkg::S_IDLE: finish = 1'b0;
            tms_pkg::S_READ: finish = !step_go && out_free;
            tms_pkg::S_RULE: finish = out_free;
            default:         finish = 1'b0;
        endcase
    end

    assign i_in.ready = i_rst_n && (r_fsm == tms_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= tms_pkg::S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd.mode       <= i_in.mode;
            r_cmd.next_state <= i_in.next_state;
            r_cmd.cidx       <= i_in.cell_index[tms_pkg::TAPE_AW-1:0];
        end
    end

    // tape: read on acceptance, write a cell command at once, write back a step
    always_comb begin
        tape_req.rd_en   = in_acc;
        tape_req.rd_addr = (i_in.mode == tms_pkg::MODE_STEP) ? r_head :
                           i_in.cell_index[tms_pkg::TAPE_AW-1:0];
        tape_req.wr_en   = (in_acc && (i_in.mode == tms_pkg::MODE_CELL)) ||
                           ((r_fsm == tms_pkg::S_RULE) && out_free);
        tape_req.wr_addr = in_acc ? i_in.cell_index[tms_pkg::TAPE_AW-1:0] : r_head;
        tape_req.wr_data = in_acc ? i_in.write_symbol : r_rule_rd.sym;
    end

    tms_tape u_tape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tape_req),
        .o_rd_data (tape_sym)
    );

    // rule table: written on acceptance, read once the tape symbol is back
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.mode == tms_pkg::MODE_RULE)) begin
            r_rule[{i_in.table_state[tms_pkg::ST_W-1:0],
                    i_in.read_symbol[tms_pkg::SYM_W-1:0]}] <=
                {i_in.write_symbol, i_in.move_dir, i_in.next_state[tms_pkg::ST_W-1:0]};
        end
        if ((r_fsm == tms_pkg::S_READ) && step_go) begin
            r_rule_rd <= r_rule[{r_state, tape_sym[tms_pkg::SYM_W-1:0]}];
        end
    end

    // head and state update
    always_comb begin
        if (r_rule_rd.move == tms_pkg::MOVE_RIGHT) begin
            moved_head = r_head + 1'b1;
        end else if (r_rule_rd.move == tms_pkg::MOVE_LEFT) begin
            moved_head = r_head - 1'b1;
        end else begin
            moved_head = r_head;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_state = r_state;
        if (finish && (r_fsm == tms_pkg::S_RULE)) begin
            n_head  = moved_head;
            n_state = r_rule_rd.next;
        end else if (finish && (r_cmd.mode == tms_pkg::MODE_SET)) begin
            n_head  = r_cmd.cidx;
            n_state = r_cmd.next_state[tms_pkg::ST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= tms_pkg::HEAD_RESET;
            r_state <= '0;
        end else begin
            r_head  <= n_head;
            r_state <= n_state;
        end
    end

    always_comb begin
        seen = '0;
        if (r_fsm == tms_pkg::S_RULE) begin
            seen = tape_sym;
        end else if (r_cmd.mode == tms_pkg::MODE_READ) begin
            seen = tape_sym;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_state  <= tms_pkg::STATE_FW'(n_state);
            r_out_head   <= tms_pkg::IDX_FW'(n_head);
            r_out_seen   <= seen;
            r_out_halted <= (tms_pkg::STATE_FW'(n_state) == r_halt);
            r_out_done   <= (r_fsm == tms_pkg::S_RULE);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_state = r_out_state;
    assign o_out.head_position = r_out_head;
    assign o_out.symbol_seen   = r_out_seen;
    assign o_out.halted        = r_out_halted;
    assign o_out.step_done     = r_out_done;

endmodule

>>> rtl/tms_chk.sv
// Port-level checker for the Turing machine step unit, bound to the top level.
// Depends on tms_pkg and on the top level's channel interfaces.
module tms_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tms_pkg::STATE_FW-1:0]  i_out_state,
    input logic [tms_pkg::IDX_FW-1:0]    i_out_head,
    input logic [tms_pkg::SYM_FW-1:0]    i_out_seen,
    input logic                          i_out_halted,
    input logic                          i_out_done
);

    logic [1:0] r_pend;
    logic       in_beat, out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // count commands taken whose result beat has not gone yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_state) &&
        $stable(i_out_head) && $stable(i_out_seen) && $stable(i_out_halted) &&
        $stable(i_out_done))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in_ready)
        else $error("command taken while previous one still in work");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result beat without a pending command");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 2'd2 |-> !i_in_ready)
        else $error("command taken with result and work both pending");

endmodule

bind turing_machine_step_unit tms_chk u_tms_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_state  (o_out.current_state),
    .i_out_head   (o_out.head_position),
    .i_out_seen   (o_out.symbol_seen),
    .i_out_halted (o_out.halted),
    .i_out_done   (o_out.step_done)
);
